// ----- design/csstrip_pkg.sv -----
// shared types and constants for the comment and blank line stripper
`timescale 1ns / 1ps
package csstrip_pkg;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QIDX_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_STAR  = 8'd42;

  // one queued run: an optional held slash, then one result
  typedef struct packed {
    logic       two_res;
    logic [7:0] chr;
    logic       is_status;
    logic       unclosed;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t head;
  } q_head_t;

endpackage

// ----- design/csstrip_front.sv -----
// lexer front end: accepts requests, tracks comment mode and queues results
`timescale 1ns / 1ps
module csstrip_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_byte,
  input  logic                in_eot,
  input  logic                q_full,
  output logic                push,
  output csstrip_pkg::run_t   push_run
);
  import csstrip_pkg::*;

  localparam logic [2:0] M_NORMAL = 3'd0;
  localparam logic [2:0] M_SLASH  = 3'd1;
  localparam logic [2:0] M_LINE   = 3'd2;
  localparam logic [2:0] M_BLOCK  = 3'd3;
  localparam logic [2:0] M_BSTAR  = 3'd4;

  logic [2:0] mode_r, mode_nxt;
  logic       lhc_r, lhc_nxt;
  logic       emit;
  logic       in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;
  assign push      = in_fire && emit;

  always_comb begin
    mode_nxt = mode_r;
    lhc_nxt  = lhc_r;
    emit     = 1'b0;
    push_run = '{two_res: 1'b0, chr: in_byte, is_status: 1'b0, unclosed: 1'b0};
    if (in_eot) begin
      emit               = 1'b1;
      push_run.two_res   = (mode_r == M_SLASH);
      push_run.chr       = 8'd0;
      push_run.is_status = 1'b1;
      push_run.unclosed  = (mode_r == M_BLOCK) || (mode_r == M_BSTAR);
      mode_nxt           = M_NORMAL;
      lhc_nxt            = 1'b0;
    end else begin
      case (mode_r)
        M_SLASH: begin
          if (in_byte == CH_SLASH) begin
            mode_nxt = M_LINE;
          end else if (in_byte == CH_STAR) begin
            mode_nxt = M_BLOCK;
          end else begin
            // held slash goes out, then the byte with the line now non-empty
            emit             = 1'b1;
            push_run.two_res = 1'b1;
            mode_nxt         = M_NORMAL;
            lhc_nxt          = (in_byte != CH_NL);
          end
        end
        M_LINE: begin
          if (in_byte == CH_NL) begin
            emit     = lhc_r;
            lhc_nxt  = 1'b0;
            mode_nxt = M_NORMAL;
          end
        end
        M_BLOCK: begin
          if (in_byte == CH_NL) begin
            emit    = lhc_r;
            lhc_nxt = 1'b0;
          end else if (in_byte == CH_STAR) begin
            mode_nxt = M_BSTAR;
          end
        end
        M_BSTAR: begin
          if (in_byte == CH_SLASH) begin
            mode_nxt = M_NORMAL;
          end else if (in_byte != CH_STAR) begin
            if (in_byte == CH_NL) begin
              emit    = lhc_r;
              lhc_nxt = 1'b0;
            end
            mode_nxt = M_BLOCK;
          end
        end
        default: begin
          mode_nxt = M_NORMAL;
          if (in_byte == CH_NL) begin
            emit    = lhc_r;
            lhc_nxt = 1'b0;
          end else if ((in_byte == CH_SP || in_byte == CH_TAB) && !lhc_r) begin
            emit = 1'b0;
          end else if (in_byte == CH_SLASH) begin
            mode_nxt = M_SLASH;
          end else begin
            emit    = 1'b1;
            lhc_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      lhc_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      lhc_r  <= lhc_nxt;
    end
  end

  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_eot |=> mode_r == M_NORMAL && !lhc_r)
    else $error("state not cleared after end of text");

endmodule

// ----- design/csstrip_fifo.sv -----
// short run queue between the lexer and the output sequencer
`timescale 1ns / 1ps
module csstrip_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  csstrip_pkg::run_t    push_run,
  input  logic                 pop,
  output logic                 full,
  output csstrip_pkg::q_head_t q_head
);
  import csstrip_pkg::*;

  run_t              mem_r [Q_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full        = (cnt_r == QCNT_W'(Q_DEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QIDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QIDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_head.valid))
    else $error("pop from empty queue");

endmodule

// ----- design/csstrip_back.sv -----
// output sequencer: expands queued runs into results behind an output register
`timescale 1ns / 1ps
module csstrip_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csstrip_pkg::q_head_t q_head,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_byte,
  output logic                 out_status,
  output logic                 out_unc,
  output logic                 out_last
);
  import csstrip_pkg::*;

  logic       valid_r, valid_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       status_r, status_nxt;
  logic       unc_r, unc_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_tready;

  always_comb begin
    pop        = 1'b0;
    phase_nxt  = phase_r;
    valid_nxt  = valid_r && !out_tready;
    byte_nxt   = byte_r;
    status_nxt = status_r;
    unc_nxt    = unc_r;
    last_nxt   = last_r;
    if (load && q_head.valid) begin
      valid_nxt = 1'b1;
      if (q_head.head.two_res && !phase_r) begin
        byte_nxt   = CH_SLASH;
        status_nxt = 1'b0;
        unc_nxt    = 1'b0;
        last_nxt   = 1'b0;
        phase_nxt  = 1'b1;
      end else begin
        byte_nxt   = q_head.head.chr;
        status_nxt = q_head.head.is_status;
        unc_nxt    = q_head.head.unclosed;
        last_nxt   = 1'b1;
        phase_nxt  = 1'b0;
        pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
    unc_r    <= unc_nxt;
    last_r   <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_byte   = byte_r;
  assign out_status = status_r;
  assign out_unc    = unc_r;
  assign out_last   = last_r;

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && status_r |-> last_r && byte_r == 8'd0)
    else $error("status result malformed");

endmodule

// ----- design/c_comment_and_blank_line_stripper.sv -----
// top level of the c comment and blank line stripper
`timescale 1ns / 1ps
// Takes one text byte per request and returns the text with // and /* */
// comments removed, leading blanks dropped and empty lines suppressed. A new
// request is accepted every cycle while the four-entry run queue has room;
// results leave one per cycle while out_tready is high, so a request that
// yields a held slash plus another result occupies the output for two
// results, the slash first. The first result of a request is written into the
// run queue when the request is accepted and then into the output register
// before it is presented. An end-of-text request emits a pending slash, then
// a status result, and returns the lexer to its reset state.
module c_comment_and_blank_line_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] is_status, [1] unclosed_comment
  output logic       out_tlast
);
  import csstrip_pkg::*;

  logic    push;
  run_t    push_run;
  logic    pop;
  logic    q_full;
  q_head_t q_head;
  logic    st_status;
  logic    st_unc;

  csstrip_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_eot    (in_tuser[0]),
    .q_full    (q_full),
    .push      (push),
    .push_run  (push_run)
  );

  csstrip_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .full     (q_full),
    .q_head   (q_head)
  );

  csstrip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_status (st_status),
    .out_unc    (st_unc),
    .out_last   (out_tlast)
  );

  assign out_tuser = {st_unc, st_status};

endmodule
